[rtl/ugl_pkg.sv]
package ugl_pkg;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 16;
	localparam int LEN_W     = 10;
	localparam int WIDTH_W   = 8;
	localparam int COUNT_W   = 8;
	localparam int SEQ_W     = 3;
	localparam int TEXT_BYTES = 65536;
	localparam int MAX_WIDTH  = 255;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd40;
	localparam logic [POS_W-1:0]   POS_MAX     = POS_W'(TEXT_BYTES - 1);
	localparam logic [LEN_W-1:0]   LEN_MAX     = '1;
	localparam logic [BYTE_W-1:0]  BYTE_NL     = 8'h0A;
	localparam logic [BYTE_W-1:0]  BYTE_SP     = 8'h20;

	typedef logic [POS_W-1:0] pos_t;

	// Line tracking state that one character updates.
	typedef struct packed {
		pos_t                 line_start;
		logic [COUNT_W-1:0]   chars_taken;
		logic [COUNT_W-1:0]   chars_since_space;
		logic                 space_seen;
		pos_t                 space_at;
		pos_t                 word_end;
		pos_t                 nonspace_end;
		logic                 skipping;
		logic                 full_wait;
	} ugl_state_t;

	// One whole character as seen by the line tracker.
	typedef struct packed {
		logic                single;
		logic [BYTE_W-1:0]   first;
		pos_t                pos;
		pos_t                nonspace_end;
	} ugl_event_t;

	typedef struct packed {
		logic               valid;
		pos_t               offset;
		logic [LEN_W-1:0]   length;
	} ugl_emit_t;

	typedef struct packed {
		pos_t               line_offset;
		logic [LEN_W-1:0]   line_length;
		logic               final_line;
		logic               last_of_run;
	} ugl_result_t;

	localparam ugl_state_t STATE_RESET = '{skipping: 1'b1, default: '0};

	// Position plus a small step, held at the last position of the text window.
	function automatic pos_t sat_add(input pos_t x, input logic [SEQ_W-1:0] k);
		logic [POS_W:0] s;
		s = {1'b0, x} + (POS_W+1)'(k);
		return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
	endfunction

	// Bytes from start up to stop, zero when stop does not lie past start, capped at LEN_MAX.
	function automatic logic [LEN_W-1:0] line_len(input pos_t start, input pos_t stop);
		pos_t             d;
		logic [LEN_W-1:0] r;
		d = stop - start;
		if (stop <= start) begin
			r = '0;
		end else if (d > POS_W'(LEN_MAX)) begin
			r = LEN_MAX;
		end else begin
			r = d[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/ugl_ifs.sv]
interface ugl_text_if;
	logic                         valid;
	logic                         ready;
	logic [ugl_pkg::BYTE_W-1:0]   text_byte;
	logic                         end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ugl_line_if;
	logic                        valid;
	logic                        ready;
	logic [ugl_pkg::POS_W-1:0]   line_offset;
	logic [ugl_pkg::LEN_W-1:0]   line_length;
	logic                        final_line;
	logic                        last_of_run;

	modport source (output valid, output line_offset, output line_length,
		output final_line, output last_of_run, input ready);
	modport sink (input valid, input line_offset, input line_length,
		input final_line, input last_of_run, output ready);
endinterface

[rtl/ugl_char_step.sv]
module ugl_char_step (
	input  ugl_pkg::ugl_state_t          cur,
	input  ugl_pkg::ugl_event_t          ev,
	input  logic [ugl_pkg::WIDTH_W-1:0]  width,
	output ugl_pkg::ugl_state_t          nxt,
	output ugl_pkg::ugl_emit_t           em
);
	import ugl_pkg::*;

	logic is_nl;
	logic is_sp;
	logic taken;
	pos_t back_start;

	function automatic ugl_state_t begin_line(input ugl_state_t s, input pos_t p);
		ugl_state_t r;
		r = s;
		r.line_start        = p;
		r.chars_taken       = '0;
		r.chars_since_space = '0;
		r.space_seen        = 1'b0;
		r.nonspace_end      = p;
		r.skipping          = 1'b0;
		r.full_wait         = 1'b0;
		return r;
	endfunction

	function automatic ugl_emit_t mk_emit(input pos_t start, input pos_t stop);
		ugl_emit_t e;
		e.valid  = 1'b1;
		e.offset = start;
		e.length = line_len(start, stop);
		return e;
	endfunction

	assign is_nl      = ev.single && (ev.first == BYTE_NL);
	assign is_sp      = ev.single && (ev.first == BYTE_SP);
	assign back_start = sat_add(cur.space_at, SEQ_W'(1));

	// A full line is only broken once the following character shows where.
	// The full-line branch never follows a skipped leading run, so the
	// values it reads from cur are the ones the line holds at that point.
	always_comb begin
		nxt   = cur;
		em    = '0;
		taken = 1'b0;
		if (cur.skipping) begin
			if (is_sp) begin
				nxt.line_start = sat_add(ev.pos, SEQ_W'(1));
				taken          = 1'b1;
			end else begin
				nxt = begin_line(cur, ev.pos);
			end
		end
		if (!taken && nxt.full_wait) begin
			nxt.full_wait = 1'b0;
			if (is_nl) begin
				em           = mk_emit(nxt.line_start, nxt.nonspace_end);
				nxt.skipping = 1'b1;
				taken        = 1'b1;
			end else if (is_sp) begin
				em             = mk_emit(nxt.line_start, nxt.nonspace_end);
				nxt.skipping   = 1'b1;
				nxt.line_start = sat_add(ev.pos, SEQ_W'(1));
				taken          = 1'b1;
			end else if (nxt.space_seen) begin
				em              = mk_emit(cur.line_start, cur.word_end);
				nxt             = begin_line(cur, back_start);
				nxt.chars_taken = cur.chars_since_space;
				if (cur.nonspace_end > back_start) begin
					nxt.nonspace_end = cur.nonspace_end;
				end
			end else begin
				em  = mk_emit(cur.line_start, cur.nonspace_end);
				nxt = begin_line(cur, ev.pos);
			end
		end
		if (!taken) begin
			if (is_nl) begin
				em           = mk_emit(nxt.line_start, nxt.nonspace_end);
				nxt.skipping = 1'b1;
			end else begin
				if (is_sp) begin
					nxt.space_at          = ev.pos;
					nxt.space_seen        = 1'b1;
					nxt.word_end          = nxt.nonspace_end;
					nxt.chars_since_space = '0;
				end else begin
					if (nxt.chars_since_space != '1) begin
						nxt.chars_since_space = nxt.chars_since_space + COUNT_W'(1);
					end
					nxt.nonspace_end = ev.nonspace_end;
				end
				nxt.chars_taken = nxt.chars_taken + COUNT_W'(1);
				if (nxt.chars_taken >= width) begin
					nxt.full_wait = 1'b1;
				end
			end
		end
	end

endmodule

[rtl/ugl_out_buf.sv]
module ugl_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ugl_pkg::ugl_result_t  push_data,
	output logic                  full,
	ugl_line_if.source            lines
);
	import ugl_pkg::*;

	logic [1:0]  count_q;
	ugl_result_t head_q;
	ugl_result_t skid_q;
	logic        pop;

	assign pop  = (count_q != 2'd0) && lines.ready;
	assign full = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if ((count_q == 2'd0) || ((count_q == 2'd1) && pop)) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if ((count_q == 2'd2) && pop) begin
			head_q <= skid_q;
		end
		if (push && (((count_q == 2'd1) && !pop) || ((count_q == 2'd2) && pop))) begin
			skid_q <= push_data;
		end
	end

	assign lines.valid       = (count_q != 2'd0);
	assign lines.line_offset = head_q.line_offset;
	assign lines.line_length = head_q.line_length;
	assign lines.final_line  = head_q.final_line;
	assign lines.last_of_run = head_q.last_of_run;

endmodule

[rtl/utf8_greedy_line_breaker.sv]
// Channel   Role  Payload                                         Request
// text      sink  text_byte[7:0], end_of_text                     valid && ready
// lines     src   line_offset[15:0], line_length[9:0],            valid && ready
//                 final_line, last_of_run
// cfg       in    cfg_data[7:0] = line_width, cfg_write           cfg_write
//
// An ordinary text byte passes the input stage and gives at most one line;
// bytes stream at one per cycle while the output buffer has room.
// The end_of_text byte runs the line tracker once per character still held,
// then flushes the open line and, when two lines are in hand at that point,
// drains the last one. A two-entry output buffer lets a new byte in while a
// line waits; the input stage stalls while that buffer is full and until an
// end_of_text byte has run its whole sequence. Reset clears the control
// state and sets line_width to 40.
module utf8_greedy_line_breaker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [ugl_pkg::WIDTH_W-1:0]  cfg_data,
	ugl_text_if.sink                     text,
	ugl_line_if.source                   lines
);
	import ugl_pkg::*;

	// Phases of the end-of-text sequence.
	localparam logic [1:0] PH_EVENT = 2'd0;
	localparam logic [1:0] PH_FLUSH = 2'd1;
	localparam logic [1:0] PH_DRAIN = 2'd2;

	localparam int CHUNK_N = 4;
	localparam int PEND_N  = 3;

	localparam logic [BYTE_W-1:0] LEAD_MIN = 8'h80;

	// Bytes in a character, taken from its lead byte.
	function automatic logic [SEQ_W-1:0] seq_len(input logic [BYTE_W-1:0] c);
		logic [SEQ_W-1:0] n;
		if (c < LEAD_MIN) begin
			n = SEQ_W'(1);
		end else if (c[7:5] == 3'b110) begin
			n = SEQ_W'(2);
		end else if (c[7:4] == 4'b1110) begin
			n = SEQ_W'(3);
		end else begin
			n = SEQ_W'(4);
		end
		return n;
	endfunction

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		if (w == '0) begin
			r = WIDTH_W'(1);
		end else if ({1'b0, w} > (WIDTH_W+1)'(MAX_WIDTH)) begin
			r = WIDTH_W'(MAX_WIDTH);
		end else begin
			r = w;
		end
		return r;
	endfunction

	function automatic ugl_result_t to_result(input ugl_emit_t e, input logic fin);
		ugl_result_t r;
		r.line_offset = e.offset;
		r.line_length = e.length;
		r.final_line  = fin;
		r.last_of_run = fin;
		return r;
	endfunction

	// Configuration and per-text width.
	logic [WIDTH_W-1:0] line_width_q;
	logic [WIDTH_W-1:0] active_width_q;
	logic [WIDTH_W-1:0] width_eff;
	logic               text_open_q;

	// Input stage.
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               eot_s1;

	// Character assembly.
	pos_t               byte_pos_q;
	pos_t               pend_lead_q;
	logic [BYTE_W-1:0]  pend_q [PEND_N];
	logic [1:0]         pend_cnt_q;

	// Line tracking and end-of-text sequencing.
	ugl_state_t         st_q;
	ugl_state_t         st_nx;
	logic [1:0]         phase_q;
	logic [1:0]         slot_q;
	ugl_emit_t          hold_q;

	logic [2:0]         chunk_len;
	logic [1:0]         slot;
	logic [BYTE_W-1:0]  chunk [CHUNK_N];
	logic [SEQ_W-1:0]   lead_len;
	logic [2:0]         left;
	logic [SEQ_W-1:0]   ev_len;
	logic [1:0]         jlast;
	logic [2:0]         slot_nx;
	pos_t               base;
	logic               ev_valid;
	ugl_event_t         ev;
	ugl_emit_t          em;
	logic               flush_v;
	ugl_emit_t          flush_em;

	logic               adv;
	logic               fire;
	logic               step_done;
	logic               push;
	ugl_result_t        push_data;
	logic               out_full;

	// The bytes in play: any held lead and continuation bytes, then the new byte.
	assign chunk_len = 3'(pend_cnt_q) + 3'd1;
	assign base      = (pend_cnt_q != 2'd0) ? pend_lead_q : byte_pos_q;

	always_comb begin
		chunk[0] = (pend_cnt_q == 2'd0) ? byte_s1 : pend_q[0];
		chunk[1] = (pend_cnt_q > 2'd1) ? pend_q[1] :
			((pend_cnt_q == 2'd1) ? byte_s1 : '0);
		chunk[2] = (pend_cnt_q == 2'd3) ? pend_q[2] :
			((pend_cnt_q == 2'd2) ? byte_s1 : '0);
		chunk[3] = (pend_cnt_q == 2'd3) ? byte_s1 : '0;
	end

	// An ordinary byte always looks at the chunk from its start. At end of
	// text the chunk is split into characters one per cycle while the output buffer
	// has room, and a lead byte whose sequence runs past the end of the text counts on its own.
	assign slot     = eot_s1 ? slot_q : 2'd0;
	assign lead_len = seq_len(chunk[slot]);
	assign left     = chunk_len - 3'(slot);
	assign ev_len   = (lead_len > left) ? SEQ_W'(1) : lead_len;
	assign ev_valid = eot_s1 ? (phase_q == PH_EVENT) : (lead_len <= left);
	assign slot_nx  = 3'(slot) + ev_len;

	// Last byte of the character that is not a space byte.
	always_comb begin
		jlast = 2'd0;
		for (int j = 0; j < CHUNK_N; j++) begin
			if ((3'(j) < ev_len) && (chunk[2'(slot + 2'(j))] != BYTE_SP)) begin
				jlast = 2'(j);
			end
		end
	end

	always_comb begin
		ev.single       = (ev_len == SEQ_W'(1));
		ev.first        = chunk[slot];
		ev.pos          = sat_add(base, SEQ_W'(slot));
		ev.nonspace_end = sat_add(base, SEQ_W'(slot) + SEQ_W'(jlast) + SEQ_W'(1));
	end

	// The width is taken from the register at the first byte of a text.
	assign width_eff = text_open_q ? active_width_q : clamp_width(line_width_q);

	ugl_char_step u_step (
		.cur   (st_q),
		.ev    (ev),
		.width (width_eff),
		.nxt   (st_nx),
		.em    (em)
	);

	assign flush_v      = !st_q.skipping;
	assign flush_em.valid  = flush_v;
	assign flush_em.offset = st_q.line_start;
	assign flush_em.length = line_len(st_q.line_start, st_q.nonspace_end);

	// The stage moves whenever the output buffer has room.
	assign adv  = valid_s1 && !out_full;
	assign fire = adv && ev_valid;

	// At end of text each new line parks in hold_q until the next one shows
	// up, so the last line of the run can carry both closing flags.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		step_done = 1'b0;
		if (adv) begin
			if (!eot_s1) begin
				step_done             = 1'b1;
				push                  = ev_valid && em.valid;
				push_data             = to_result(em, 1'b0);
				push_data.last_of_run = 1'b1;
			end else begin
				unique case (phase_q)
					PH_EVENT: begin
						push      = em.valid && hold_q.valid;
						push_data = to_result(hold_q, 1'b0);
					end
					PH_FLUSH: begin
						if (flush_v) begin
							push = 1'b1;
							if (hold_q.valid) begin
								push_data = to_result(hold_q, 1'b0);
							end else begin
								push_data = to_result(flush_em, 1'b1);
								step_done = 1'b1;
							end
						end else begin
							push      = hold_q.valid;
							push_data = to_result(hold_q, 1'b1);
							step_done = 1'b1;
						end
					end
					PH_DRAIN: begin
						push      = 1'b1;
						push_data = to_result(hold_q, 1'b1);
						step_done = 1'b1;
					end
					default: begin
						step_done = 1'b1;
					end
				endcase
			end
		end
	end

	assign text.ready = !valid_s1 || step_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= WIDTH_RESET;
			active_width_q <= WIDTH_RESET;
			text_open_q    <= 1'b0;
			valid_s1       <= 1'b0;
			byte_pos_q     <= '0;
			pend_cnt_q     <= 2'd0;
			st_q           <= STATE_RESET;
			phase_q        <= PH_EVENT;
			slot_q         <= 2'd0;
			hold_q         <= '0;
		end else begin
			if (cfg_write) begin
				line_width_q <= cfg_data;
			end
			if (text.valid && text.ready) begin
				valid_s1 <= 1'b1;
			end else if (step_done) begin
				valid_s1 <= 1'b0;
			end
			if (adv && !text_open_q) begin
				text_open_q    <= 1'b1;
				active_width_q <= width_eff;
			end
			if (fire) begin
				st_q <= st_nx;
			end
			if (adv && !eot_s1) begin
				byte_pos_q <= sat_add(byte_pos_q, SEQ_W'(1));
				if (fire) begin
					pend_cnt_q <= 2'd0;
				end else begin
					pend_cnt_q <= pend_cnt_q + 2'd1;
				end
			end
			if (adv && eot_s1) begin
				unique case (phase_q)
					PH_EVENT: begin
						if (em.valid) begin
							hold_q <= em;
						end
						if (slot_nx >= chunk_len) begin
							phase_q <= PH_FLUSH;
						end else begin
							slot_q <= slot_nx[1:0];
						end
					end
					PH_FLUSH: begin
						if (flush_v && hold_q.valid) begin
							hold_q  <= flush_em;
							phase_q <= PH_DRAIN;
						end
					end
					PH_DRAIN: ;
					default: phase_q <= PH_EVENT;
				endcase
				// The text is over: everything but the width register starts afresh.
				if (step_done) begin
					text_open_q <= 1'b0;
					byte_pos_q  <= '0;
					pend_cnt_q  <= 2'd0;
					st_q        <= STATE_RESET;
					phase_q     <= PH_EVENT;
					slot_q      <= 2'd0;
					hold_q      <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			eot_s1  <= text.end_of_text;
		end
		// A byte that does not finish a character is held with its lead position.
		if (adv && !eot_s1 && !fire) begin
			unique case (pend_cnt_q)
				2'd0: begin
					pend_q[0]   <= byte_s1;
					pend_lead_q <= byte_pos_q;
				end
				2'd1: pend_q[1] <= byte_s1;
				2'd2: pend_q[2] <= byte_s1;
				default: ;
			endcase
		end
	end

	ugl_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (out_full),
		.lines     (lines)
	);

endmodule
